// ===== design/mrfd_pkg.sv =====
`timescale 1ns / 1ps

package mrfd_pkg;

  // Field widths of the frame header facts.
  localparam int AddrW = 16;
  localparam int LenW = 7;
  localparam int SeqW = 8;
  localparam int KindW = 3;

  // History of (sender, sequence) pairs used by the duplicate check.
  localparam int HistDepth = 8;

  // Depth of the queue between the classifier and the history stage.
  localparam int QDepth = 2;
  localparam int QPtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW = $clog2(QDepth + 1);

  // Configuration port.
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegOwnAddress = 3'd0;
  localparam logic [CfgIdxW-1:0] RegIgnoreAck = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAddrFilter = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDupCheck = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSendAck = 3'd4;

  // Frame constants.
  localparam logic [LenW-1:0] AckFrameLen = 7'd3;
  localparam logic [KindW-1:0] KindData = 3'd1;
  localparam logic [AddrW-1:0] NullAddress = '0;

  typedef enum logic [2:0] {
    VERDICT_DELIVER     = 3'd0,
    VERDICT_IGNORED_ACK = 3'd1,
    VERDICT_PARSE_FAIL  = 3'd2,
    VERDICT_NOT_FOR_US  = 3'd3,
    VERDICT_DUPLICATE   = 3'd4
  } verdict_t;

  typedef struct packed {
    logic             parse_ok;
    logic [LenW-1:0]  frame_length;
    logic [AddrW-1:0] dest_address;
    logic [AddrW-1:0] src_address;
    logic [SeqW-1:0]  sequence_number;
    logic [KindW-1:0] frame_kind;
    logic             ack_request;
  } in_t;

  typedef struct packed {
    verdict_t        verdict;
    logic            send_ack;
    logic [SeqW-1:0] ack_sequence;
  } out_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    verdict_t         early_verdict;
    logic             reach;
    logic             dup_check;
    logic             ack_cand;
    logic [AddrW-1:0] src;
    logic [SeqW-1:0]  seq;
  } q_item_t;

  // Handshake between two stages.
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

// ===== design/mrfd_front.sv =====
`timescale 1ns / 1ps

module mrfd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mrfd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mrfd_pkg::CfgDataW-1:0] cfg_data,
  input  mrfd_pkg::in_t                 req,
  output mrfd_pkg::q_item_t             item
);

  logic [mrfd_pkg::AddrW-1:0] own_address_r;
  logic                       ignore_ack_r;
  logic                       addr_filter_r;
  logic                       dup_check_r;
  logic                       send_ack_r;

  logic ignored;
  logic not_for_us;
  logic to_us;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r <= '0;
      ignore_ack_r  <= 1'b0;
      addr_filter_r <= 1'b1;
      dup_check_r   <= 1'b0;
      send_ack_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mrfd_pkg::RegOwnAddress: own_address_r <= cfg_data[mrfd_pkg::AddrW-1:0];
        mrfd_pkg::RegIgnoreAck:  ignore_ack_r  <= cfg_data[0];
        mrfd_pkg::RegAddrFilter: addr_filter_r <= cfg_data[0];
        mrfd_pkg::RegDupCheck:   dup_check_r   <= cfg_data[0];
        mrfd_pkg::RegSendAck:    send_ack_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Filter checks in priority order: ignored ack, parse failure, address.
  assign ignored    = ignore_ack_r && (req.frame_length == mrfd_pkg::AckFrameLen);
  assign to_us      = (req.dest_address == own_address_r);
  assign not_for_us = addr_filter_r && !to_us
                      && (req.dest_address != mrfd_pkg::NullAddress);

  always_comb begin
    item.reach         = 1'b0;
    item.early_verdict = mrfd_pkg::VERDICT_DELIVER;
    if (ignored) begin
      item.early_verdict = mrfd_pkg::VERDICT_IGNORED_ACK;
    end else if (!req.parse_ok) begin
      item.early_verdict = mrfd_pkg::VERDICT_PARSE_FAIL;
    end else if (not_for_us) begin
      item.early_verdict = mrfd_pkg::VERDICT_NOT_FOR_US;
    end else begin
      item.reach = 1'b1;
    end
    item.dup_check = item.reach && dup_check_r;
    item.ack_cand  = item.reach && send_ack_r && to_us && req.ack_request
                     && (req.frame_kind == mrfd_pkg::KindData);
    item.src       = req.src_address;
    item.seq       = req.sequence_number;
  end

endmodule

// ===== design/mrfd_queue.sv =====
`timescale 1ns / 1ps

module mrfd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  mrfd_pkg::q_item_t push_item,
  output mrfd_pkg::hs_t     pop_hs_o,
  input  logic              pop_ready,
  output mrfd_pkg::q_item_t pop_item
);

  mrfd_pkg::q_item_t             slot_r [mrfd_pkg::QDepth];
  logic [mrfd_pkg::QPtrW-1:0]    wr_ptr_r;
  logic [mrfd_pkg::QPtrW-1:0]    rd_ptr_r;
  logic [mrfd_pkg::QCntW-1:0]    count_r;
  logic [mrfd_pkg::QCntW-1:0]    count_nxt;
  logic                          do_push;
  logic                          do_pop;

  localparam logic [mrfd_pkg::QPtrW-1:0] LastPtr = mrfd_pkg::QPtrW'(mrfd_pkg::QDepth - 1);
  localparam logic [mrfd_pkg::QCntW-1:0] FullCnt = mrfd_pkg::QCntW'(mrfd_pkg::QDepth);

  assign push_ready     = (count_r != FullCnt);
  assign pop_hs_o.valid = (count_r != '0);
  assign pop_hs_o.ready = pop_ready;
  assign pop_item       = slot_r[rd_ptr_r];
  assign do_push        = push_valid && push_ready;
  assign do_pop         = pop_hs_o.valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // Storage slots carry payload only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== design/mrfd_back.sv =====
`timescale 1ns / 1ps

module mrfd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mrfd_pkg::hs_t     q_hs,
  input  mrfd_pkg::q_item_t q_item,
  output logic              q_pop_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mrfd_pkg::out_t    out_data
);

  logic [mrfd_pkg::AddrW-1:0] hist_sender_r [mrfd_pkg::HistDepth];
  logic [mrfd_pkg::SeqW-1:0]  hist_seq_r    [mrfd_pkg::HistDepth];
  logic                       out_valid_r;
  mrfd_pkg::out_t             out_r;
  mrfd_pkg::out_t             out_nxt;
  logic                       hit;
  logic                       take;
  logic                       do_push;

  // The output register frees when empty or when its result is taken.
  assign q_pop_ready = !out_valid_r || out_ready;
  assign take        = q_hs.valid && q_hs.ready;
  assign out_valid   = out_valid_r;
  assign out_data    = out_r;

  // Compare the pair against every history entry at once.
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < mrfd_pkg::HistDepth; i++) begin
      if (hist_sender_r[i] == q_item.src && hist_seq_r[i] == q_item.seq) begin
        hit = 1'b1;
      end
    end
  end

  assign do_push = take && q_item.dup_check && !hit;

  // Final verdict and acknowledgment.
  always_comb begin
    out_nxt.verdict = q_item.early_verdict;
    if (q_item.reach) begin
      out_nxt.verdict = (q_item.dup_check && hit) ? mrfd_pkg::VERDICT_DUPLICATE
                                                  : mrfd_pkg::VERDICT_DELIVER;
    end
    out_nxt.send_ack     = q_item.ack_cand;
    out_nxt.ack_sequence = q_item.ack_cand ? q_item.seq : '0;
  end

  // History shift line: a new pair enters at the front.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mrfd_pkg::HistDepth; i++) begin
        hist_sender_r[i] <= '0;
        hist_seq_r[i]    <= '0;
      end
    end else if (do_push) begin
      hist_sender_r[0] <= q_item.src;
      hist_seq_r[0]    <= q_item.seq;
      for (int i = 1; i < mrfd_pkg::HistDepth; i++) begin
        hist_sender_r[i] <= hist_sender_r[i-1];
        hist_seq_r[i]    <= hist_seq_r[i-1];
      end
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop_ready) begin
      out_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== design/mac_rx_filter_dedup_ack.sv =====
`timescale 1ns / 1ps

// Receive filter for an 802.15.4 MAC: each accepted request of parsed header
// facts yields exactly one result with a verdict and an optional ack request.
// The block takes one request per cycle and returns one result per cycle while
// the result side keeps out_ready high; a result passes through a queue slot
// and then the output register before it is offered on out_valid. The
// classifier feeds a two-entry queue, and the history stage compares all eight
// (sender, sequence) entries in parallel and shifts the history in the same
// cycle, so a frame sees the history left by the frame before it. When the
// result side stalls, the output register and both queue entries fill, and
// in_ready drops after three requests (after two if a result was already
// waiting); it rises again right after the edge at which a result is taken.
// Configuration writes are taken in any cycle but must only be issued while
// no request is in flight; the history clears to zero at reset.

module mac_rx_filter_dedup_ack (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mrfd_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mrfd_pkg::out_t                out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mrfd_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mrfd_pkg::CfgDataW-1:0] cfg_data
);

  mrfd_pkg::q_item_t front_item;
  mrfd_pkg::q_item_t q_item;
  mrfd_pkg::hs_t     q_hs;
  logic              q_pop_ready;

  mrfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (in_data),
    .item      (front_item)
  );

  mrfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_item),
    .pop_hs_o   (q_hs),
    .pop_ready  (q_pop_ready),
    .pop_item   (q_item)
  );

  mrfd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_hs        (q_hs),
    .q_item      (q_item),
    .q_pop_ready (q_pop_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ===== tb/sv/frame_filter_sb_pkg.sv =====
`timescale 1ns / 1ps

package frame_filter_sb_pkg;

  import mrfd_pkg::*;

  // Tracks the filter's register copy and duplicate history, predicts one verdict per
  // accepted request and checks the results in order.
  class frame_verdict_sb;

    // Register copy.
    logic [AddrW-1:0] own_addr;
    bit               ignore_acks;
    bit               addr_filter_on;
    bit               dup_check_on;
    bit               ack_on;

    // Recently delivered (sender, sequence) pairs, newest at entry 0.
    logic [AddrW-1:0] seen_src[HistDepth];
    logic [SeqW-1:0]  seen_seq[HistDepth];

    // Verdicts still owed by the block, oldest first.
    out_t             owed_verdicts[$];

    int               errors;
    int               checked;
    int               verdict_tally[5];
    int               ack_tally;

    function new();
      own_addr       = '0;
      ignore_acks    = 1'b0;
      addr_filter_on = 1'b1;
      dup_check_on   = 1'b0;
      ack_on         = 1'b0;
      foreach (seen_src[i]) begin
        seen_src[i] = '0;
        seen_seq[i] = '0;
      end
      errors    = 0;
      checked   = 0;
      ack_tally = 0;
      foreach (verdict_tally[i]) verdict_tally[i] = 0;
    endfunction

    // Prints one line per mismatch and counts them all.
    task report(string msg);
      $display("[%0t ns] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Mirrors a register write; indexes past the last register are dropped.
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        RegOwnAddress: own_addr = value[AddrW-1:0];
        RegIgnoreAck: ignore_acks = value[0];
        RegAddrFilter: addr_filter_on = value[0];
        RegDupCheck: dup_check_on = value[0];
        RegSendAck: ack_on = value[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_verdicts.size();
    endfunction

    // Works out the verdict for an accepted request and updates the history.
    function void note_request(in_t f);
      out_t want;
      bit   hit;
      want = '0;
      hit  = 1'b0;
      if (ignore_acks && f.frame_length == AckFrameLen) begin
        want.verdict = VERDICT_IGNORED_ACK;
      end else if (!f.parse_ok) begin
        want.verdict = VERDICT_PARSE_FAIL;
      end else if (addr_filter_on && f.dest_address != own_addr &&
                   f.dest_address != NullAddress) begin
        want.verdict = VERDICT_NOT_FOR_US;
      end else begin
        // The history is only searched and shifted while the check is on.
        if (dup_check_on) begin
          foreach (seen_src[i]) begin
            if (seen_src[i] == f.src_address && seen_seq[i] == f.sequence_number) begin
              hit = 1'b1;
            end
          end
          if (!hit) begin
            for (int i = HistDepth - 1; i > 0; i--) begin
              seen_src[i] = seen_src[i-1];
              seen_seq[i] = seen_seq[i-1];
            end
            seen_src[0] = f.src_address;
            seen_seq[0] = f.sequence_number;
          end
        end
        // Duplicates are acknowledged as well.
        if (ack_on && f.frame_kind == KindData && f.ack_request &&
            f.dest_address == own_addr) begin
          want.send_ack     = 1'b1;
          want.ack_sequence = f.sequence_number;
        end
        want.verdict = hit ? VERDICT_DUPLICATE : VERDICT_DELIVER;
      end
      owed_verdicts.push_back(want);
    endfunction

    // Compares an accepted result with the oldest owed verdict.
    task check_result(out_t got);
      out_t want;
      if (owed_verdicts.size() == 0) begin
        report($sformatf("result verdict=%0d with no request pending", got.verdict));
        return;
      end
      want = owed_verdicts.pop_front();
      checked++;
      verdict_tally[int'(want.verdict)]++;
      if (want.send_ack) ack_tally++;
      if (got.verdict !== want.verdict) begin
        report($sformatf("verdict got %0d want %0d", got.verdict, want.verdict));
      end
      if (got.send_ack !== want.send_ack) begin
        report($sformatf("send_ack got %0b want %0b", got.send_ack, want.send_ack));
      end
      if (got.ack_sequence !== want.ack_sequence) begin
        report($sformatf("ack_sequence got %0h want %0h", got.ack_sequence,
                         want.ack_sequence));
      end
    endtask

    task flag_leftovers();
      if (owed_verdicts.size() != 0) begin
        report($sformatf("%0d results never arrived", owed_verdicts.size()));
      end
    endtask

  endclass

endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  import mrfd_pkg::*;
  import frame_filter_sb_pkg::*;

  localparam int NumPhases      = 9;
  localparam int FramesPerPhase = 144;
  localparam int HoldCycles     = 64;
  localparam int DrainCycles    = 6;
  localparam int StallLimit     = 2000;
  localparam int RecentDepth    = 12;
  localparam logic [CfgIdxW-1:0] FirstUnusedReg = RegSendAck + 3'd1;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  in_t            in_data;
  logic           out_valid;
  logic           out_ready;
  out_t           out_data;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  frame_verdict_sb sb;

  int  send_gap_pct;
  int  recv_stall_pct;
  bit  hold_results;
  int  idle_cycles;
  int  n_settings;
  logic [AddrW+SeqW-1:0] recent_pairs[$];

  mac_rx_filter_dedup_ack i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Every accepted result is checked against the prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
  end

  // Ends the run when no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               StallLimit, sb.pending());
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, or a long hold-off when the main flow asks for one.
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_results = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Builds one request from explicit field values.
  function automatic in_t frame(bit ok, int len, int dest, int src, int seq, int kind,
                                bit ack_req);
    in_t f;
    f.parse_ok        = ok;
    f.frame_length    = LenW'(len);
    f.dest_address    = AddrW'(dest);
    f.src_address     = AddrW'(src);
    f.sequence_number = SeqW'(seq);
    f.frame_kind      = KindW'(kind);
    f.ack_request     = ack_req;
    return f;
  endfunction

  // Mostly well-formed frames for this node, with senders and sequences often reused
  // so that the history gets hits, misses and entries that have just fallen out.
  function automatic in_t random_frame();
    in_t f;
    int  pick;
    f.parse_ok     = ($urandom_range(99) < 88);
    f.frame_length = ($urandom_range(99) < 15) ? AckFrameLen : LenW'($urandom);
    pick = $urandom_range(99);
    if (pick < 35) begin
      f.dest_address = sb.own_addr;
    end else if (pick < 55) begin
      f.dest_address = NullAddress;
    end else if (pick < 62) begin
      f.dest_address = '1;
    end else begin
      f.dest_address = AddrW'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 45 && recent_pairs.size() > 0) begin
      {f.src_address, f.sequence_number} =
        recent_pairs[$urandom_range(recent_pairs.size() - 1)];
    end else if (pick < 55) begin
      f.src_address     = AddrW'($urandom_range(3));
      f.sequence_number = SeqW'($urandom_range(3));
    end else begin
      f.src_address     = AddrW'($urandom);
      f.sequence_number = SeqW'($urandom);
    end
    f.frame_kind  = ($urandom_range(99) < 50) ? KindData : KindW'($urandom);
    f.ack_request = 1'($urandom);
    return f;
  endfunction

  // Offers one request after a random gap and holds it until it is taken.
  task automatic send_frame(input in_t f);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (!in_ready);
    sb.note_request(f);
    recent_pairs.push_front({f.src_address, f.sequence_number});
    if (recent_pairs.size() > RecentDepth) void'(recent_pairs.pop_back());
    @(negedge clk);
  endtask

  // Stops offering and waits until every owed result has come back.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    @(negedge clk);
  endtask

  // Writes all five registers; the one-bit ones get random upper data bits.
  task automatic configure(input logic [AddrW-1:0] own, input bit ign, input bit filt,
                           input bit dup, input bit ack);
    write_reg(RegOwnAddress, CfgDataW'(own));
    write_reg(RegIgnoreAck, {15'($urandom), ign});
    write_reg(RegAddrFilter, {15'($urandom), filt});
    write_reg(RegDupCheck, {15'($urandom), dup});
    write_reg(RegSendAck, {15'($urandom), ack});
    cfg_valid <= 1'b0;
    n_settings++;
    @(negedge clk);
  endtask

  // Main flow: reset, directed frames, then random phases under changing settings.
  initial begin
    logic [3:0] flags;
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_results   = 1'b0;
    idle_cycles    = 0;
    n_settings     = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Own address zero with every check on: the cleared history makes sender 0 with
    // sequence 0 a duplicate, and the null destination counts as this node.
    configure(16'h0000, 1'b1, 1'b1, 1'b1, 1'b1);
    send_frame(frame(1, 20, 16'h0000, 16'h0000, 8'h00, KindData, 1));
    send_frame(frame(1, 3, 16'h0000, 16'h0005, 8'h05, KindData, 1));
    send_frame(frame(0, 3, 16'hFFFF, 16'h0005, 8'h05, KindData, 1));
    send_frame(frame(0, 10, 16'h0000, 16'h0005, 8'h05, KindData, 1));
    send_frame(frame(1, 127, 16'hFFFF, 16'h0005, 8'h05, KindData, 1));
    send_frame(frame(1, 0, 16'h0000, 16'hFFFF, 8'hFF, KindData, 1));
    send_frame(frame(1, 0, 16'h0000, 16'hFFFF, 8'hFF, KindData, 1));
    send_frame(frame(1, 127, 16'h0000, 16'hFFFF, 8'hFE, 7, 0));
    send_frame(frame(1, 40, 16'hFFFF, 16'h0005, 8'h05, KindData, 1));
    wait_drain();

    // Filter and duplicate check off, own address all ones; writes past the last
    // register must not disturb anything.
    configure(16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b1);
    for (int k = FirstUnusedReg; k < 2 ** CfgIdxW; k++) begin
      write_reg(CfgIdxW'(k), '1);
    end
    cfg_valid <= 1'b0;
    @(negedge clk);
    send_frame(frame(1, 3, 16'hFFFF, 16'h0001, 8'h01, KindData, 1));
    send_frame(frame(1, 3, 16'hFFFF, 16'h0001, 8'h01, KindData, 1));
    send_frame(frame(1, 50, 16'h1234, 16'h0002, 8'h10, KindData, 1));
    send_frame(frame(1, 50, 16'h0000, 16'h0002, 8'h11, KindData, 1));
    send_frame(frame(0, 50, 16'hFFFF, 16'h0002, 8'h12, KindData, 1));
    send_frame(frame(1, 1, 16'hFFFF, 16'h0000, 8'h00, 0, 1));
    send_frame(frame(1, 60, 16'hFFFF, 16'h0003, 8'h13, KindData, 0));
    wait_drain();

    // Acks off with the filter on and a nonzero own address.
    configure(16'h8001, 1'b0, 1'b1, 1'b1, 1'b0);
    send_frame(frame(1, 64, 16'h8001, 16'h7FFE, 8'h80, KindData, 1));
    send_frame(frame(1, 64, 16'h0000, 16'h7FFE, 8'h81, KindData, 1));
    send_frame(frame(1, 64, 16'h8001, 16'h7FFE, 8'h80, KindData, 1));
    wait_drain();

    // Random phases: sender idles lightly and receiver heavily, then the reverse,
    // then neither idles.
    for (int p = 0; p < NumPhases; p++) begin
      if (p < 3) begin
        send_gap_pct   = 20;
        recv_stall_pct = 71;
      end else if (p < 6) begin
        send_gap_pct   = 71;
        recv_stall_pct = 20;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      // Flags are ignore-ack, address filter, duplicate check, send-ack.
      case (p)
        0: flags = 4'b0111;
        1: flags = 4'b1111;
        2: flags = 4'b0000;
        default: flags = {1'($urandom), 1'($urandom), ($urandom_range(3) != 0),
                          1'($urandom)};
      endcase
      configure((p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : AddrW'($urandom),
                flags[3], flags[2], flags[1], flags[0]);
      // Hold the result side off while requests keep coming so the block backs up.
      if (p == 0 || p == 3) hold_results = 1'b1;
      for (int n = 0; n < FramesPerPhase; n++) begin
        send_frame(random_frame());
      end
      wait_drain();
    end

    sb.flag_leftovers();
    $display("Checked %0d results over %0d register settings, %0d of them acks.",
             sb.checked, n_settings, sb.ack_tally);
    $display("Delivered %0d, ignored acks %0d, parse fails %0d, not for us %0d, dups %0d.",
             sb.verdict_tally[VERDICT_DELIVER], sb.verdict_tally[VERDICT_IGNORED_ACK],
             sb.verdict_tally[VERDICT_PARSE_FAIL], sb.verdict_tally[VERDICT_NOT_FOR_US],
             sb.verdict_tally[VERDICT_DUPLICATE]);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
